>>> rtl/rm2q_pkg.sv
// Shared types and constants for the rotation matrix to quaternion core.
// No dependencies.
package rm2q_pkg;

  localparam int ROOT_STEPS = 15;  // result bits of the 30-bit square root
  localparam int DIV_STEPS  = 29;  // quotient bits of the scaled-term divide
  localparam int LATENCY    = ROOT_STEPS + DIV_STEPS + 3;

  localparam logic signed [15:0] QMAX = 16'sh7FFF;
  localparam logic signed [15:0] QMIN = -16'sh8000;

  typedef logic signed [16:0] num_t;   // sum or difference of two elements
  typedef num_t [2:0] num3_t;          // the three non-dominant numerators

  typedef struct packed {
    logic [14:0] rem;
    logic [28:0] dvd;
    logic [28:0] quo;
    logic        neg;
    logic        nz;
  } lane_t;

  typedef lane_t [2:0] lane3_t;

endpackage

>>> rtl/rotation_matrix_to_quaternion_core.sv
// Rotation matrix (Q2.14) to unit quaternion (Q2.14), fully pipelined.
// Pipeline from start to out_valid: setup, square root, prep, divide and output stages.
// Throughput: one request per cycle; busy is always low since results cannot be held off.
// The square root resolves one result bit per stage; each of three divide lanes
// resolves one quotient bit per stage.
// Reset: rst_n synchronous, active low; clears all valid bits, payload is not reset.
module rotation_matrix_to_quaternion_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_r0c0,
  input  logic signed [15:0] in_r0c1,
  input  logic signed [15:0] in_r0c2,
  input  logic signed [15:0] in_r1c0,
  input  logic signed [15:0] in_r1c1,
  input  logic signed [15:0] in_r1c2,
  input  logic signed [15:0] in_r2c0,
  input  logic signed [15:0] in_r2c1,
  input  logic signed [15:0] in_r2c2,
  output logic               out_valid,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w
);

  localparam int RS = rm2q_pkg::ROOT_STEPS;
  localparam int DS = rm2q_pkg::DIV_STEPS;

  // The pipeline never stalls, so every request is taken.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Setup stage: trace, branch, dominant axis, radicand and numerators.
  // ---------------------------------------------------------------------
  logic signed [17:0] d0, d1, d2, tr, a;
  logic signed [18:0] rad;
  logic [1:0]         axis, dom_nxt;
  logic [28:0]        rad_nxt;
  rm2q_pkg::num3_t    num_nxt;
  rm2q_pkg::num_t     nx, ny, nz, s01, s02, s12;

  always_comb begin
    d0  = 18'(in_r0c0);
    d1  = 18'(in_r1c1);
    d2  = 18'(in_r2c2);
    tr  = d0 + d1 + d2;
    nx  = 17'(in_r2c1) - 17'(in_r1c2);
    ny  = 17'(in_r0c2) - 17'(in_r2c0);
    nz  = 17'(in_r1c0) - 17'(in_r0c1);
    s01 = 17'(in_r0c1) + 17'(in_r1c0);
    s02 = 17'(in_r0c2) + 17'(in_r2c0);
    s12 = 17'(in_r1c2) + 17'(in_r2c1);
    // Ties keep the lower axis.
    axis = 2'd0;
    if (d1 > d0) axis = 2'd1;
    if ((axis == 2'd1) ? (d2 > d1) : (d2 > d0)) axis = 2'd2;
    if (tr > 0) begin
      dom_nxt = 2'd3;
      a       = tr;
      num_nxt = {nz, ny, nx};
    end else begin
      dom_nxt = axis;
      case (axis)
        2'd0: begin
          a       = d0 - d1 - d2;
          num_nxt = {nx, s02, s01};    // y, z, w
        end
        2'd1: begin
          a       = d1 - d2 - d0;
          num_nxt = {ny, s12, s01};    // x, z, w
        end
        default: begin
          a       = d2 - d0 - d1;
          num_nxt = {nz, s12, s02};    // x, y, w
        end
      endcase
    end
    rad = 19'(a) + 19'sd16384;
    // Clamp a negative radicand (not a rotation) to zero, then scale by 4096.
    rad_nxt = rad[18] ? 29'd0 : {rad[16:0], 12'd0};
  end

  // ---------------------------------------------------------------------
  // Square root pipeline: one result bit per stage.
  // ---------------------------------------------------------------------
  logic              sq_v_r   [0:RS];
  logic [29:0]       sq_rem_r [0:RS];
  logic [29:0]       sq_res_r [0:RS];
  rm2q_pkg::num3_t   sq_num_r [0:RS];
  logic [1:0]        sq_dom_r [0:RS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= start;
    end
    sq_rem_r[0] <= 30'(rad_nxt);
    sq_res_r[0] <= '0;
    sq_num_r[0] <= num_nxt;
    sq_dom_r[0] <= dom_nxt;
  end

  for (genvar s = 0; s < RS; s++) begin : g_root
    localparam logic [29:0] BIT = 30'(1) << (2 * (RS - 1 - s));
    logic [29:0] trial;
    logic [29:0] rem_nxt, res_nxt;
    always_comb begin
      trial = sq_res_r[s] + BIT;
      if (sq_rem_r[s] >= trial) begin
        rem_nxt = sq_rem_r[s] - trial;
        res_nxt = (sq_res_r[s] >> 1) + BIT;
      end else begin
        rem_nxt = sq_rem_r[s];
        res_nxt = sq_res_r[s] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[s+1] <= 1'b0;
      end else begin
        sq_v_r[s+1] <= sq_v_r[s];
      end
      sq_rem_r[s+1] <= rem_nxt;
      sq_res_r[s+1] <= res_nxt;
      sq_num_r[s+1] <= sq_num_r[s];
      sq_dom_r[s+1] <= sq_dom_r[s];
    end
  end

  // ---------------------------------------------------------------------
  // Prep stage: round the root, build dividends mag*4096 + den/2.
  // ---------------------------------------------------------------------
  logic [14:0]      root_rnd;
  rm2q_pkg::lane3_t lane_nxt;

  always_comb begin
    logic [16:0] mag;
    root_rnd = sq_res_r[RS][14:0] + 15'(sq_rem_r[RS] > sq_res_r[RS]);
    for (int l = 0; l < 3; l++) begin
      // A sum of two most negative elements has magnitude 2^16: keep 17 bits.
      mag = sq_num_r[RS][l][16] ? 17'(-sq_num_r[RS][l]) : 17'(sq_num_r[RS][l]);
      lane_nxt[l].neg = sq_num_r[RS][l][16];
      lane_nxt[l].nz  = (sq_num_r[RS][l] != '0);
      lane_nxt[l].rem = '0;
      lane_nxt[l].quo = '0;
      lane_nxt[l].dvd = {mag, 12'd0} + 29'(root_rnd >> 1);
    end
  end

  logic             dv_v_r    [0:DS];
  logic [14:0]      dv_den_r  [0:DS];
  logic [1:0]       dv_dom_r  [0:DS];
  rm2q_pkg::lane3_t dv_lane_r [0:DS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[RS];
    end
    dv_den_r[0]  <= root_rnd;
    dv_dom_r[0]  <= sq_dom_r[RS];
    dv_lane_r[0] <= lane_nxt;
  end

  // ---------------------------------------------------------------------
  // Restoring divide: three lanes share the divisor, one bit per stage.
  // ---------------------------------------------------------------------
  for (genvar s = 0; s < DS; s++) begin : g_div
    rm2q_pkg::lane3_t step;
    always_comb begin
      logic [15:0] part;
      for (int l = 0; l < 3; l++) begin
        part        = {dv_lane_r[s][l].rem, dv_lane_r[s][l].dvd[28]};
        step[l]     = dv_lane_r[s][l];
        step[l].dvd = {dv_lane_r[s][l].dvd[27:0], 1'b0};
        if (part >= {1'b0, dv_den_r[s]}) begin
          step[l].rem = 15'(part - {1'b0, dv_den_r[s]});
          step[l].quo = {dv_lane_r[s][l].quo[27:0], 1'b1};
        end else begin
          step[l].rem = part[14:0];
          step[l].quo = {dv_lane_r[s][l].quo[27:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[s+1] <= 1'b0;
      end else begin
        dv_v_r[s+1] <= dv_v_r[s];
      end
      dv_den_r[s+1]  <= dv_den_r[s];
      dv_dom_r[s+1]  <= dv_dom_r[s];
      dv_lane_r[s+1] <= step;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: saturate each lane, then place lanes around the root.
  // ---------------------------------------------------------------------
  logic signed [15:0] term [0:2];
  logic signed [15:0] root_q;
  logic [1:0]         dom;
  logic signed [15:0] slot [0:3];
  logic signed [15:0] slot_r [0:3];
  logic               out_valid_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_den_r[DS] == '0) begin
        // Zero divisor: saturate by sign of the numerator.
        if (!dv_lane_r[DS][l].nz)      term[l] = '0;
        else if (dv_lane_r[DS][l].neg) term[l] = rm2q_pkg::QMIN;
        else                           term[l] = rm2q_pkg::QMAX;
      end else if (dv_lane_r[DS][l].neg) begin
        term[l] = (dv_lane_r[DS][l].quo > 29'd32768) ? rm2q_pkg::QMIN
                : 16'(-dv_lane_r[DS][l].quo[15:0]);
      end else begin
        term[l] = (dv_lane_r[DS][l].quo > 29'd32767) ? rm2q_pkg::QMAX
                : dv_lane_r[DS][l].quo[15:0];
      end
    end
    // Slots below the dominant one take their own lane, slots above it shift down one.
    root_q  = {1'b0, dv_den_r[DS]};
    dom     = dv_dom_r[DS];
    slot[0] = (dom == 2'd0) ? root_q : term[0];
    slot[1] = (dom == 2'd1) ? root_q : ((dom == 2'd0) ? term[0] : term[1]);
    slot[2] = (dom == 2'd2) ? root_q : ((dom == 2'd3) ? term[2] : term[1]);
    slot[3] = (dom == 2'd3) ? root_q : term[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[DS];
    end
    for (int s = 0; s < 4; s++) slot_r[s] <= slot[s];
  end

  assign out_valid  = out_valid_r;
  assign out_quat_x = slot_r[0];
  assign out_quat_y = slot_r[1];
  assign out_quat_z = slot_r[2];
  assign out_quat_w = slot_r[3];

endmodule

>>> rtl/rm2q_checker.sv
// Port-level checks for the rotation matrix to quaternion core.
// Depends on rm2q_pkg; bound to rotation_matrix_to_quaternion_core.
module rm2q_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  localparam int LAT = rm2q_pkg::LATENCY;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_request_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after request");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without request");

endmodule

bind rotation_matrix_to_quaternion_core rm2q_checker u_rm2q_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
